>>> hw/rtl/lcd_rect_flush_streamer_defines.svh
// Assertion macros shared by the streamer RTL.
// Both sample on clk and are disabled while arst_n is low.
`ifndef LCD_RECT_FLUSH_STREAMER_DEFINES_SVH
`define LCD_RECT_FLUSH_STREAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRFS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/lrfs_pkg.sv
package lrfs_pkg;

	localparam int SCREEN_WIDTH  = 160;
	localparam int SCREEN_HEIGHT = 128;
	localparam int MAX_TX_BYTES  = 40960;

	localparam int STORE_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int PIX_W       = 16;

	// Operation codes carried on the input side.
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_FLUSH   = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;

	// Configuration register indexes.
	localparam logic [0:0] REG_COL_OFFSET = 1'd0;
	localparam logic [0:0] REG_ROW_OFFSET = 1'd1;

	// Header sequencer steps; the last one streams pixels.
	localparam logic [3:0] STEP_CASET    = 4'd0;
	localparam logic [3:0] STEP_CS_HI    = 4'd1;
	localparam logic [3:0] STEP_CS_LO    = 4'd2;
	localparam logic [3:0] STEP_CE_HI    = 4'd3;
	localparam logic [3:0] STEP_CE_LO    = 4'd4;
	localparam logic [3:0] STEP_RASET    = 4'd5;
	localparam logic [3:0] STEP_RS_HI    = 4'd6;
	localparam logic [3:0] STEP_RS_LO    = 4'd7;
	localparam logic [3:0] STEP_RE_HI    = 4'd8;
	localparam logic [3:0] STEP_RE_LO    = 4'd9;
	localparam logic [3:0] STEP_RAMWR    = 4'd10;
	localparam logic [3:0] STEP_PIXEL    = 4'd11;

	// Panel command bytes.
	localparam logic [7:0] CMD_CASET = 8'h2A;
	localparam logic [7:0] CMD_RASET = 8'h2B;
	localparam logic [7:0] CMD_RAMWR = 8'h2C;
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

>>> hw/rtl/lrfs_ram.sv
module lrfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/lcd_rect_flush_streamer.sv
// Channel  Dir  Handshake             Word contents
// s        in   s_tvalid / s_tready   operation on s_tuser, geometry and color on s_tdata
// m        out  m_tvalid / m_tready   status and SPI byte on m_tdata, D/C on m_tuser, m_tlast
// cfg      in   cfg_valid / cfg_ready register index and 8-bit value, always ready
//
// Every input word has an accept cycle, in which the frame store is addressed at
// the pixel cursor, and then an execute cycle, in which the registered store read
// is used and the result word is loaded; no new word is taken in the execute cycle.
// The RAM's registered read sets this split. Reset clears all control state; the
// frame store is not cleared and must be written before it is flushed. A stalled
// output word holds the input side off until it is taken or leaves in the same cycle.
`include "lcd_rect_flush_streamer_defines.svh"

module lcd_rect_flush_streamer
	import lrfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	// [9:0] pos_x, [19:10] pos_y, [28:20] rect_width, [37:29] rect_height,
	// [53:38] pixel_color, [55:54] zero
	input  logic [55:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,

	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] accepted, [1] byte_valid, [9:2] out_byte, [10] busy_res, [15:11] zero
	output logic [15:0] m_tdata,
	// [0] is_data
	output logic        m_tuser,
	// last_byte
	output logic        m_tlast,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	state_t state_q, state_d;

	// Configuration registers.
	logic [7:0] col_off_q, row_off_q;

	// The accepted word, held for the execute cycle.
	logic [1:0]        op_q;
	logic signed [9:0] px_q, py_q;
	logic [8:0]        w_q, h_q;
	logic [15:0]       color_q;

	// Flush state.
	logic       busy_q, busy_d;
	logic [3:0] hdr_step_q, hdr_step_d;
	logic [7:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic [7:0] clip_left_d, clip_top_d, clip_right_d, clip_bottom_d;
	logic [7:0] cur_col_q, cur_row_q, cur_col_d, cur_row_d;
	logic       low_q, low_d;

	// Output register.
	logic       m_tvalid_q;
	logic       res_acc_q, res_valid_q, res_data_q, res_last_q, res_busy_q;
	logic [7:0] res_byte_q;
	logic       res_acc_d, res_valid_d, res_data_d, res_last_d;
	logic [7:0] res_byte_d;

	// Frame store ports.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [PIX_W-1:0]  ram_rdata;

	logic s_accept;
	logic out_free;

	// Pixel write check.
	logic wr_ok;

	// Flush clipping.
	logic [9:0]         x0, y0;
	logic signed [10:0] x0s, y0s, x1s, y1s, x1c, y1c;
	logic [7:0]         dx, dy;
	logic [15:0]        area;
	logic [16:0]        tx_bytes;
	logic               fl_ok;

	// Address bytes.
	logic [8:0] cs, ce, rs, re;

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, res_busy_q, res_byte_q, res_valid_q, res_acc_q};
	assign m_tuser  = res_data_q;
	assign m_tlast  = res_last_q;

	// The store is read at the cursor every cycle; the cursor does not move between
	// the accept cycle and the execute cycle, so the data is ready when needed.
	assign ram_raddr = ADDR_W'(cur_row_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cur_col_q);
	assign ram_waddr = ADDR_W'(py_q[7:0]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(px_q[7:0]);

	lrfs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (color_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		wr_ok = !busy_q && !px_q[9] && (px_q < 10'(SCREEN_WIDTH))
			&& !py_q[9] && (py_q < 10'(SCREEN_HEIGHT));
	end

	// Clip the rectangle against the screen and check that it is not empty, that no flush is busy and the transfer size.
	always_comb begin
		x0  = px_q[9] ? 10'd0 : px_q;
		y0  = py_q[9] ? 10'd0 : py_q;
		x0s = {1'b0, x0};
		y0s = {1'b0, y0};
		x1s = {px_q[9], px_q} + {2'b00, w_q};
		y1s = {py_q[9], py_q} + {2'b00, h_q};
		x1c = (x1s > $signed(11'(SCREEN_WIDTH))) ? $signed(11'(SCREEN_WIDTH)) : x1s;
		y1c = (y1s > $signed(11'(SCREEN_HEIGHT))) ? $signed(11'(SCREEN_HEIGHT)) : y1s;
		dx  = 8'(x1c - x0s);
		dy  = 8'(y1c - y0s);
		area     = dx * dy;
		tx_bytes = {area, 1'b0};
		fl_ok = (w_q != 9'd0) && (h_q != 9'd0) && !busy_q
			&& (x1c > x0s) && (y1c > y0s) && (tx_bytes <= 17'(MAX_TX_BYTES));
	end

	always_comb begin
		cs = 9'(clip_left_q) + 9'(col_off_q);
		ce = 9'(clip_right_q) + 9'(col_off_q);
		rs = 9'(clip_top_q) + 9'(row_off_q);
		re = 9'(clip_bottom_q) + 9'(row_off_q);
	end

	// Next state and result of the execute cycle.
	always_comb begin
		state_d       = state_q;
		busy_d        = busy_q;
		hdr_step_d    = hdr_step_q;
		clip_left_d   = clip_left_q;
		clip_top_d    = clip_top_q;
		clip_right_d  = clip_right_q;
		clip_bottom_d = clip_bottom_q;
		cur_col_d     = cur_col_q;
		cur_row_d     = cur_row_q;
		low_d         = low_q;
		ram_we        = 1'b0;
		res_acc_d     = 1'b0;
		res_valid_d   = 1'b0;
		res_byte_d    = 8'd0;
		res_data_d    = 1'b0;
		res_last_d    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (op_q)
					OP_WRITE: begin
						if (wr_ok) begin
							ram_we    = 1'b1;
							res_acc_d = 1'b1;
						end
					end
					OP_FLUSH: begin
						if (fl_ok) begin
							clip_left_d   = x0[7:0];
							clip_top_d    = y0[7:0];
							clip_right_d  = 8'(x1c - 11'sd1);
							clip_bottom_d = 8'(y1c - 11'sd1);
							cur_col_d     = x0[7:0];
							cur_row_d     = y0[7:0];
							low_d         = 1'b0;
							hdr_step_d    = STEP_CASET;
							busy_d        = 1'b1;
							res_acc_d     = 1'b1;
						end
					end
					OP_ADVANCE: begin
						if (busy_q) begin
							res_acc_d   = 1'b1;
							res_valid_d = 1'b1;
							res_data_d  = 1'b1;
							unique case (hdr_step_q)
								STEP_CASET: begin
									res_byte_d = CMD_CASET;
									res_data_d = 1'b0;
								end
								STEP_CS_HI: res_byte_d = {7'd0, cs[8]};
								STEP_CS_LO: res_byte_d = cs[7:0] & BYTE_MASK;
								STEP_CE_HI: res_byte_d = {7'd0, ce[8]};
								STEP_CE_LO: res_byte_d = ce[7:0] & BYTE_MASK;
								STEP_RASET: begin
									res_byte_d = CMD_RASET;
									res_data_d = 1'b0;
								end
								STEP_RS_HI: res_byte_d = {7'd0, rs[8]};
								STEP_RS_LO: res_byte_d = rs[7:0] & BYTE_MASK;
								STEP_RE_HI: res_byte_d = {7'd0, re[8]};
								STEP_RE_LO: res_byte_d = re[7:0] & BYTE_MASK;
								STEP_RAMWR: begin
									res_byte_d = CMD_RAMWR;
									res_data_d = 1'b0;
								end
								default: begin
									// Pixel streaming: high byte, then low byte and
									// a raster step of the cursor.
									if (!low_q) begin
										res_byte_d = ram_rdata[15:8];
										low_d      = 1'b1;
									end else begin
										res_byte_d = ram_rdata[7:0];
										low_d      = 1'b0;
										if (cur_col_q >= clip_right_q) begin
											cur_col_d = clip_left_q;
											if (cur_row_q >= clip_bottom_q) begin
												res_last_d = 1'b1;
												busy_d     = 1'b0;
												hdr_step_d = STEP_CASET;
											end else begin
												cur_row_d = cur_row_q + 8'd1;
											end
										end else begin
											cur_col_d = cur_col_q + 8'd1;
										end
									end
								end
							endcase
							if (hdr_step_q < STEP_PIXEL && busy_d) begin
								hdr_step_d = hdr_step_q + 4'd1;
							end
						end
					end
					default: ;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			hdr_step_q    <= STEP_CASET;
			clip_left_q   <= 8'd0;
			clip_top_q    <= 8'd0;
			clip_right_q  <= 8'd0;
			clip_bottom_q <= 8'd0;
			cur_col_q     <= 8'd0;
			cur_row_q     <= 8'd0;
			low_q         <= 1'b0;
			col_off_q     <= 8'd0;
			row_off_q     <= 8'd0;
			m_tvalid_q    <= 1'b0;
		end else begin
			busy_q        <= busy_d;
			hdr_step_q    <= hdr_step_d;
			clip_left_q   <= clip_left_d;
			clip_top_q    <= clip_top_d;
			clip_right_q  <= clip_right_d;
			clip_bottom_q <= clip_bottom_d;
			cur_col_q     <= cur_col_d;
			cur_row_q     <= cur_row_d;
			low_q         <= low_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_COL_OFFSET: col_off_q <= cfg_data;
					REG_ROW_OFFSET: row_off_q <= cfg_data;
				endcase
			end
			if (state_q == S_EXEC) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q    <= s_tuser;
			px_q    <= s_tdata[9:0];
			py_q    <= s_tdata[19:10];
			w_q     <= s_tdata[28:20];
			h_q     <= s_tdata[37:29];
			color_q <= s_tdata[53:38];
		end
		if (state_q == S_EXEC) begin
			res_acc_q   <= res_acc_d;
			res_valid_q <= res_valid_d;
			res_byte_q  <= res_byte_d;
			res_data_q  <= res_data_d;
			res_last_q  <= res_last_d;
			res_busy_q  <= busy_d;
		end
	end

	`LRFS_ASSERT_NEXT(a_accept_to_exec, s_accept, state_q == S_EXEC, "accepted word not executed")
	`LRFS_ASSERT_SAME(a_out_free, state_q == S_EXEC, !m_tvalid_q, "result register still full")
	`LRFS_ASSERT_SAME(a_no_write_busy, ram_we, !busy_q, "frame store written during flush")
	`LRFS_ASSERT_SAME(a_step_range, busy_q, hdr_step_q <= STEP_PIXEL, "header step out of range")
	`LRFS_ASSERT_SAME(a_last_ends, m_tvalid_q && res_last_q, !res_busy_q && res_valid_q,
		"last byte without end of flush")

endmodule
